/* rtl/core/cpot_pkg.sv */
`timescale 1ns / 1ps

package cpot_pkg;

    localparam int CW  = 32;          // coordinate width, Q16.16
    localparam int DW  = CW + 1;      // exact difference
    localparam int SQW = 2 * DW;      // square of a difference magnitude
    localparam int SW  = SQW + 2;     // sum of three squares
    localparam int RB  = CW - 1;      // root bits, one per stage
    localparam int VW  = CW + 3;      // exact distance before saturation
    localparam int NAX = 3;           // axes, one lane each

    localparam logic PK_BOX    = 1'b0;
    localparam logic PK_SPHERE = 1'b1;

    typedef logic signed [CW-1:0] t_coord;
    typedef logic signed [DW-1:0] t_ax;
    typedef logic        [SQW-1:0] t_sq;
    typedef logic        [SW-1:0] t_sum;
    typedef logic        [RB-1:0] t_root;
    typedef logic signed [VW-1:0] t_val;

    // kind of the request and the value that rides alongside the root:
    // box distance in box mode, radius sum in sphere mode
    typedef struct packed {
        logic kind;
        t_val val;
    } t_tag;

endpackage

/* rtl/core/cpot_lane.sv */
`timescale 1ns / 1ps

module cpot_lane
    import cpot_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_en,
    input  t_coord i_a_lo,
    input  t_coord i_a_hi,
    input  t_coord i_b_lo,
    input  t_coord i_b_hi,
    output t_ax    o_ax,
    output t_sq    o_sq
);

    t_ax              w_d1;
    t_ax              w_d2;
    t_ax              w_dc;
    logic [DW-1:0]    n_mag;

    t_ax              r_ax1;
    logic [DW-1:0]    r_mag;
    t_ax              r_ax2;
    t_sq              r_sq;

    always_comb begin
        w_d1  = DW'(i_b_lo) - DW'(i_a_hi);
        w_d2  = DW'(i_a_lo) - DW'(i_b_hi);
        w_dc  = DW'(i_b_lo) - DW'(i_a_lo);
        n_mag = w_dc[DW-1] ? DW'(-w_dc) : DW'(w_dc);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ax1 <= (w_d1 > w_d2) ? w_d1 : w_d2;
            r_mag <= n_mag;
            r_ax2 <= r_ax1;
            r_sq  <= SQW'(r_mag) * SQW'(r_mag);
        end
    end

    assign o_ax = r_ax2;
    assign o_sq = r_sq;

endmodule

/* rtl/core/cpot_merge.sv */
`timescale 1ns / 1ps

module cpot_merge
    import cpot_pkg::*;
(
    input  logic i_clk,
    input  logic i_en,
    input  t_ax  i_ax [NAX],
    input  t_sq  i_sq [NAX],
    input  logic i_kind,
    input  t_val i_rsum,
    output t_sum o_sum,
    output t_tag o_tag
);

    t_ax  w_m01;
    t_ax  w_box;
    t_tag n_tag;
    t_sum r_sum;
    t_tag r_tag;

    always_comb begin
        w_m01      = (i_ax[1] > i_ax[0]) ? i_ax[1] : i_ax[0];
        w_box      = (i_ax[2] > w_m01) ? i_ax[2] : w_m01;
        n_tag.kind = i_kind;
        n_tag.val  = (i_kind == PK_SPHERE) ? i_rsum : VW'(w_box);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum <= SW'(i_sq[0]) + SW'(i_sq[1]) + SW'(i_sq[2]);
            r_tag <= n_tag;
        end
    end

    assign o_sum = r_sum;
    assign o_tag = r_tag;

endmodule

/* rtl/core/cpot_root.sv */
`timescale 1ns / 1ps

module cpot_root
    import cpot_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_en,
    input  t_sum  i_sum,
    input  t_tag  i_tag,
    output t_root o_root,
    output t_tag  o_tag
);

    // restoring square root, one result bit per stage, msb first;
    // all bits set is the saturated value
    t_sum  w_rem [RB+1];
    t_root w_rt  [RB+1];
    t_tag  w_tg  [RB+1];

    assign w_rem[0] = i_sum;
    assign w_rt[0]  = '0;
    assign w_tg[0]  = i_tag;

    for (genvar k = 0; k < RB; k++) begin : g_stage
        localparam int B = RB - 1 - k;

        t_sum  w_trial;
        t_sum  n_rem;
        t_root n_rt;
        t_sum  r_rem;
        t_root r_rt;
        t_tag  r_tg;

        always_comb begin
            w_trial = (SW'(w_rt[k]) << (B + 1)) + (SW'(1) << (2 * B));
            n_rem   = w_rem[k];
            n_rt    = w_rt[k];
            if (w_rem[k] >= w_trial) begin
                n_rem   = w_rem[k] - w_trial;
                n_rt[B] = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem <= n_rem;
                r_rt  <= n_rt;
                r_tg  <= w_tg[k];
            end
        end

        assign w_rem[k+1] = r_rem;
        assign w_rt[k+1]  = r_rt;
        assign w_tg[k+1]  = r_tg;
    end

    assign o_root = w_rt[RB];
    assign o_tag  = w_tg[RB];

endmodule

/* rtl/core/collider_pair_overlap_test_core.sv */
`timescale 1ns / 1ps

// Collider pair overlap test, signed Q16.16. One pair request is taken every
// cycle while the result side keeps up. The deepest part is the square root,
// a pipeline of RB = 31 stages that each settle one bit of the centre distance;
// ahead of it three axis lanes form differences and squares over two stages and
// a merge stage forms the box maximum and the sum of squares. Box pairs take the
// same path so that results leave in request order. pair_kind is sampled with
// each request; write it only while the block is idle.
module collider_pair_overlap_test_core
    import cpot_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_cfg_valid,
    output logic   o_cfg_ready,
    input  logic   i_cfg_pair_kind,
    input  logic   i_in_valid,
    output logic   o_in_ready,
    input  t_coord i_a_lo_x,
    input  t_coord i_a_lo_y,
    input  t_coord i_a_lo_z,
    input  t_coord i_a_hi_x,
    input  t_coord i_a_hi_y,
    input  t_coord i_a_hi_z,
    input  t_coord i_b_lo_x,
    input  t_coord i_b_lo_y,
    input  t_coord i_b_lo_z,
    input  t_coord i_b_hi_x,
    input  t_coord i_b_hi_y,
    input  t_coord i_b_hi_z,
    output logic   o_out_valid,
    input  logic   i_out_ready,
    output logic   o_collides,
    output t_coord o_signed_distance
);

    localparam int NST = RB + 3;

    logic   r_kind;
    logic   w_en;
    logic   [NST-1:0] r_vld;
    logic   r_out_valid;
    logic   r_collides;
    t_coord r_dist;

    logic   r_kind1;
    logic   r_kind2;
    t_val   r_rsum1;
    t_val   r_rsum2;

    t_coord w_a_lo [NAX];
    t_coord w_a_hi [NAX];
    t_coord w_b_lo [NAX];
    t_coord w_b_hi [NAX];
    t_ax    w_ax   [NAX];
    t_sq    w_sq   [NAX];
    t_sum   w_sum;
    t_tag   w_mtag;
    t_root  w_root;
    t_tag   w_rtag;
    t_val   w_fin;
    t_coord n_dist;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind <= PK_BOX;
        end else if (i_cfg_valid) begin
            r_kind <= i_cfg_pair_kind;
        end
    end

    // whole pipeline moves together while the output register can take a result
    assign w_en       = !r_out_valid || i_out_ready;
    assign o_in_ready = w_en;

    assign w_a_lo = '{i_a_lo_x, i_a_lo_y, i_a_lo_z};
    assign w_a_hi = '{i_a_hi_x, i_a_hi_y, i_a_hi_z};
    assign w_b_lo = '{i_b_lo_x, i_b_lo_y, i_b_lo_z};
    assign w_b_hi = '{i_b_hi_x, i_b_hi_y, i_b_hi_z};

    for (genvar a = 0; a < NAX; a++) begin : g_lane
        cpot_lane u_lane (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_a_lo (w_a_lo[a]),
            .i_a_hi (w_a_hi[a]),
            .i_b_lo (w_b_lo[a]),
            .i_b_hi (w_b_hi[a]),
            .o_ax   (w_ax[a]),
            .o_sq   (w_sq[a])
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_kind1 <= r_kind;
            r_rsum1 <= VW'(i_a_hi_x) + VW'(i_b_hi_x);
            r_kind2 <= r_kind1;
            r_rsum2 <= r_rsum1;
        end
    end

    cpot_merge u_merge (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_ax   (w_ax),
        .i_sq   (w_sq),
        .i_kind (r_kind2),
        .i_rsum (r_rsum2),
        .o_sum  (w_sum),
        .o_tag  (w_mtag)
    );

    cpot_root u_root (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_sum  (w_sum),
        .i_tag  (w_mtag),
        .o_root (w_root),
        .o_tag  (w_rtag)
    );

    always_comb begin
        if (w_rtag.kind == PK_SPHERE) begin
            w_fin = signed'(VW'(w_root)) - w_rtag.val;
        end else begin
            w_fin = w_rtag.val;
        end
        if (w_fin[VW-1:CW-1] == '0 || w_fin[VW-1:CW-1] == '1) begin
            n_dist = w_fin[CW-1:0];
        end else if (w_fin[VW-1]) begin
            n_dist = {1'b1, {(CW-1){1'b0}}};
        end else begin
            n_dist = {1'b0, {(CW-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_vld       <= {r_vld[NST-2:0], i_in_valid};
            r_out_valid <= r_vld[NST-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_collides <= w_fin[VW-1];
            r_dist     <= n_dist;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_collides        = r_collides;
    assign o_signed_distance = r_dist;

endmodule

/* tb/sv/tb_collider_pair_overlap_test_core.sv */
`timescale 1ns / 1ps

module tb_collider_pair_overlap_test_core;
    import cpot_pkg::*;

    localparam int HALF_PERIOD  = 6;
    localparam int RESET_CYCLES = 5;
    localparam int IDLE_PCT     = 38;
    localparam int FLUSH_CYCLES = 45;
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 3000;

    localparam t_coord ONE  = 32'sh0001_0000;
    localparam t_coord MAXC = 32'sh7fff_ffff;
    localparam t_coord MINC = 32'sh8000_0000;
    localparam int     SPAN = 32'h0003_0000;
    localparam int     EXT  = 32'h0002_0000;

    typedef struct packed {
        t_coord [2:0] a_lo;
        t_coord [2:0] a_hi;
        t_coord [2:0] b_lo;
        t_coord [2:0] b_hi;
    } t_pair;

    typedef struct packed {
        logic   collides;
        t_coord distance;
    } t_overlap;

    class overlap_scoreboard;
        logic     kind;
        int       failures;
        t_overlap pending[$];

        function new();
            kind     = PK_BOX;
            failures = 0;
        endfunction

        function longint sx(logic [CW-1:0] c);
            return longint'($signed(c));
        endfunction

        function t_overlap overlap_distance(t_pair p);
            longint       sep, d1, d2, ax, m;
            logic [127:0] sumsq, sq, cand, root;
            t_overlap     r;
            if (kind == PK_BOX) begin
                sep = 0;
                for (int i = 0; i < NAX; i++) begin
                    d1 = sx(p.b_lo[i]) - sx(p.a_hi[i]);
                    d2 = sx(p.a_lo[i]) - sx(p.b_hi[i]);
                    ax = d1 > d2 ? d1 : d2;
                    if (i == 0 || ax > sep) sep = ax;
                end
            end else begin
                sumsq = '0;
                for (int i = 0; i < NAX; i++) begin
                    m = sx(p.b_lo[i]) - sx(p.a_lo[i]);
                    if (m < 0) m = -m;
                    sq = 128'(m);
                    sumsq = sumsq + sq * sq;
                end
                root = '0;
                for (int b = RB - 1; b >= 0; b--) begin
                    cand = root | (128'd1 << b);
                    if (cand * cand <= sumsq) root = cand;
                end
                sep = longint'(root[62:0]) - (sx(p.a_hi[0]) + sx(p.b_hi[0]));
            end
            r.collides = sep < 0;
            if (sep > (64'sd1 <<< (CW - 1)) - 1)
                r.distance = MAXC;
            else if (sep < -(64'sd1 <<< (CW - 1)))
                r.distance = MINC;
            else
                r.distance = t_coord'(sep);
            return r;
        endfunction

        function void note_pair(t_pair p);
            pending.push_back(overlap_distance(p));
        endfunction

        function void check_result(logic collides, t_coord distance);
            t_overlap want;
            if (pending.size() == 0) begin
                failures++;
                $display("%0t: result with nothing outstanding, collides %0b distance %0d",
                         $time, collides, $signed(distance));
                return;
            end
            want = pending.pop_front();
            if (collides !== want.collides) begin
                failures++;
                $display("%0t: collides expected %0b actual %0b",
                         $time, want.collides, collides);
            end
            if (distance !== want.distance) begin
                failures++;
                $display("%0t: signed_distance expected %0d actual %0d",
                         $time, $signed(want.distance), $signed(distance));
            end
        endfunction
    endclass

    logic   i_clk = 1'b0;
    logic   i_rst_n;
    logic   i_cfg_valid;
    logic   o_cfg_ready;
    logic   i_cfg_pair_kind;
    logic   i_in_valid;
    logic   o_in_ready;
    t_coord i_a_lo_x, i_a_lo_y, i_a_lo_z, i_a_hi_x, i_a_hi_y, i_a_hi_z;
    t_coord i_b_lo_x, i_b_lo_y, i_b_lo_z, i_b_hi_x, i_b_hi_y, i_b_hi_z;
    logic   o_out_valid;
    logic   i_out_ready;
    logic   o_collides;
    t_coord o_signed_distance;

    overlap_scoreboard sb;
    bit steady        = 1'b0;
    bit hold_request  = 1'b0;
    int hold_left     = 0;
    int quiet_cycles  = 0;

    collider_pair_overlap_test_core i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_pair_kind   (i_cfg_pair_kind),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_a_lo_x          (i_a_lo_x),
        .i_a_lo_y          (i_a_lo_y),
        .i_a_lo_z          (i_a_lo_z),
        .i_a_hi_x          (i_a_hi_x),
        .i_a_hi_y          (i_a_hi_y),
        .i_a_hi_z          (i_a_hi_z),
        .i_b_lo_x          (i_b_lo_x),
        .i_b_lo_y          (i_b_lo_y),
        .i_b_lo_z          (i_b_lo_z),
        .i_b_hi_x          (i_b_hi_x),
        .i_b_hi_y          (i_b_hi_y),
        .i_b_hi_z          (i_b_hi_z),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_collides        (o_collides),
        .o_signed_distance (o_signed_distance)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // result side: check, then pick next ready
    initial begin
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready)
                sb.check_result(o_collides, o_signed_distance);
            if (hold_request) begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    function automatic t_pair pair_of(t_coord alx, t_coord aly, t_coord alz,
                                      t_coord ahx, t_coord ahy, t_coord ahz,
                                      t_coord blx, t_coord bly, t_coord blz,
                                      t_coord bhx, t_coord bhy, t_coord bhz);
        t_pair p;
        p.a_lo = {alz, aly, alx};
        p.a_hi = {ahz, ahy, ahx};
        p.b_lo = {blz, bly, blx};
        p.b_hi = {bhz, bhy, bhx};
        return p;
    endfunction

    function automatic t_coord near_coord();
        return $urandom_range(0, 2 * SPAN) - SPAN;
    endfunction

    function automatic t_coord any_coord();
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: begin
                case ($urandom_range(0, 4))
                    0: return MINC;
                    1: return MAXC;
                    2: return '0;
                    3: return -1;
                    default: return 1;
                endcase
            end
            default: return near_coord();
        endcase
    endfunction

    function automatic t_pair noise_pair();
        return pair_of(any_coord(), any_coord(), any_coord(), any_coord(),
                       any_coord(), any_coord(), any_coord(), any_coord(),
                       any_coord(), any_coord(), any_coord(), any_coord());
    endfunction

    function automatic t_pair box_pair();
        t_pair p;
        if ($urandom_range(0, 9) == 0) return noise_pair();
        for (int i = 0; i < NAX; i++) begin
            p.a_lo[i] = near_coord();
            p.a_hi[i] = p.a_lo[i] + $urandom_range(0, EXT);
            p.b_lo[i] = near_coord();
            p.b_hi[i] = p.b_lo[i] + $urandom_range(0, EXT);
            // occasional inverted extent
            if ($urandom_range(0, 19) == 0) p.a_hi[i] = p.a_lo[i] - $urandom_range(0, EXT);
        end
        return p;
    endfunction

    function automatic t_pair sphere_pair();
        t_pair p;
        if ($urandom_range(0, 9) == 0) return noise_pair();
        p = pair_of(near_coord(), near_coord(), near_coord(), $urandom_range(0, SPAN),
                    $urandom, $urandom,
                    near_coord(), near_coord(), near_coord(), $urandom_range(0, SPAN),
                    $urandom, $urandom);
        if ($urandom_range(0, 19) == 0) p.b_hi[0] = -$urandom_range(0, SPAN);
        return p;
    endfunction

    task automatic send_pair(t_pair p);
        if (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < IDLE_PCT);
        end
        i_a_lo_x   <= p.a_lo[0];
        i_a_lo_y   <= p.a_lo[1];
        i_a_lo_z   <= p.a_lo[2];
        i_a_hi_x   <= p.a_hi[0];
        i_a_hi_y   <= p.a_hi[1];
        i_a_hi_z   <= p.a_hi[2];
        i_b_lo_x   <= p.b_lo[0];
        i_b_lo_y   <= p.b_lo[1];
        i_b_lo_z   <= p.b_lo[2];
        i_b_hi_x   <= p.b_hi[0];
        i_b_hi_y   <= p.b_hi[1];
        i_b_hi_z   <= p.b_hi[2];
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_pair(p);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending.size() != 0);
    endtask

    task automatic write_pair_kind(logic kind);
        drain_results();
        repeat (FLUSH_CYCLES) @(posedge i_clk);
        i_cfg_pair_kind <= kind;
        i_cfg_valid     <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.kind = kind;
    endtask

    initial begin
        sb = new();
        i_rst_n         <= 1'b0;
        i_cfg_valid     <= 1'b0;
        i_cfg_pair_kind <= PK_BOX;
        i_in_valid      <= 1'b0;
        {i_a_lo_x, i_a_lo_y, i_a_lo_z, i_a_hi_x, i_a_hi_y, i_a_hi_z} <= '0;
        {i_b_lo_x, i_b_lo_y, i_b_lo_z, i_b_hi_x, i_b_hi_y, i_b_hi_z} <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // box requests under the reset kind
        send_pair(pair_of('0, '0, '0, 2*ONE, 2*ONE, 2*ONE, ONE, ONE, ONE, 3*ONE, 3*ONE, 3*ONE));
        send_pair(pair_of('0, '0, '0, ONE, ONE, ONE, ONE, '0, '0, 2*ONE, ONE, ONE));
        send_pair(pair_of('0, '0, '0, ONE, ONE, ONE, '0, '0, 5*ONE, ONE, ONE, 7*ONE));
        send_pair(pair_of(-ONE, -ONE, -ONE, ONE, ONE, ONE, -ONE, -ONE, -ONE, ONE, ONE, ONE));
        send_pair(pair_of(MINC, MINC, MINC, MAXC, MAXC, MAXC, MINC, MINC, MINC, MAXC, MAXC, MAXC));
        send_pair(pair_of(MINC, MINC, MINC, MINC, MINC, MINC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC));
        send_pair(pair_of(2*ONE, '0, '0, '0, ONE, ONE, ONE, '0, '0, 3*ONE, ONE, ONE));
        send_pair(pair_of('0, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0));
        send_pair(pair_of(-1, -1, -1, -1, -1, -1, 1, 1, 1, 1, 1, 1));
        send_pair(pair_of(MAXC, '0, '0, MINC, '0, '0, MINC, '0, '0, MAXC, '0, '0));

        write_pair_kind(PK_SPHERE);
        send_pair(pair_of('0, '0, '0, '0, $urandom, $urandom, '0, '0, '0, '0, $urandom, $urandom));
        send_pair(pair_of('0, '0, '0, ONE, MAXC, MINC, 3*ONE, 4*ONE, '0, ONE, MINC, MAXC));
        send_pair(pair_of('0, '0, '0, 3*ONE, '0, '0, 3*ONE, 4*ONE, '0, 3*ONE, '0, '0));
        send_pair(pair_of(MINC, MINC, MINC, '0, '1, '1, MAXC, MAXC, MAXC, '0, '1, '1));
        send_pair(pair_of(ONE, ONE, ONE, MAXC, '0, '0, ONE, ONE, ONE, MAXC, '0, '0));
        send_pair(pair_of(MINC, '0, '0, MINC, '0, '0, MAXC, '0, '0, MINC, '0, '0));
        send_pair(pair_of('0, '0, '0, -ONE, '0, '0, 2*ONE, '0, '0, ONE, '0, '0));
        send_pair(pair_of('0, '0, '0, '0, '0, '0, 1, '0, '0, '0, '0, '0));
        send_pair(pair_of('0, '0, '0, '0, '0, '0, ONE, ONE, ONE, '0, '0, '0));
        send_pair(pair_of(-ONE, 2*ONE, -3*ONE, ONE/2, '1, '1, ONE, -ONE, ONE, ONE/2, '1, '1));

        write_pair_kind(PK_BOX);
        for (int n = 0; n < 250; n++) begin
            if (n == 20) hold_request = 1'b1;
            if (n == 150) drain_results();
            send_pair(box_pair());
        end

        write_pair_kind(PK_SPHERE);
        for (int n = 0; n < 250; n++) send_pair(sphere_pair());

        // back-to-back stretch on both sides
        steady = 1'b1;
        write_pair_kind(PK_BOX);
        for (int n = 0; n < 100; n++) send_pair(box_pair());
        write_pair_kind(PK_SPHERE);
        for (int n = 0; n < 100; n++) send_pair(sphere_pair());
        steady = 1'b0;

        drain_results();
        repeat (FLUSH_CYCLES) @(posedge i_clk);
        if (sb.failures == 0 && sb.pending.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
